// ===== design/sirdx_pkg.sv =====
package sirdx_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0]  CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_A        = 8'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 6'd9;
    localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    // Control of the digit cell row
    typedef struct packed {
        logic clear;     // zero every cell
        logic shift_in;  // double and add one magnitude bit
        logic shift_up;  // move each digit one place towards the top
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d > DIGIT_MAX)
            digit_char = d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, LETTER_BASE} + CH_A;
        else
            digit_char = d_ext + CH_ZERO;
    endfunction

endpackage

// ===== design/signed_int_to_radix_ascii.sv =====
// Signed integer to radix text.
// Input channel (in_valid / in_stall / value): one signed VALUE_WIDTH-bit integer
// per transfer. Output channel (out_valid / out_stall / char_code / last_char):
// the text form in the configured radix, most significant digit first, one ASCII
// character per transfer; a negative value is led by '-', digits above 9 use
// 'A' to 'Z', and last_char marks the final character. Zero gives a single '0'.
// Configuration: radix_we / radix_wdata write the radix (reset 10); values
// below 2 or above 36 act as 2 and 36. Write it only while the block is idle.
// Operation: the magnitude is shifted MSB first through a row of digit cells,
// one bit per cycle, until every magnitude bit has entered the cells.
// Emission then walks the cells from the top, one cell per cycle while the
// output register can take a character: leading zero cells are dropped, each
// other cell gives one character, and the sign goes out first. in_stall is
// high from acceptance until the last character is loaded into the output
// register. A stalled output holds its character and simply holds emission.
// Reset empties the output register, returns to idle and sets the radix to 10.
module signed_int_to_radix_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              radix_we,
    input  logic [sirdx_pkg::DIGIT_W-1:0]     radix_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sirdx_pkg::CHAR_W-1:0]      char_code,
    output logic                              last_char
);
    import sirdx_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   started_reg, started_next;
    logic [DIGIT_W-1:0]     radix_reg, radix_next;
    logic [DIGIT_W-1:0]     radix_eff_reg, radix_eff_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;

    logic                   in_accept;
    logic [VALUE_WIDTH-1:0] value_u;
    cell_ctrl_t             cell_ctrl;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   can_load;
    logic                   ld;
    logic [CHAR_W-1:0]      ld_char;
    logic                   ld_last;
    logic                   skip;
    logic                   cnt_one;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign value_u   = value;
    assign cnt_one   = (cnt_reg == CNT_W'(1));

    // Leading zero cell: drop it unless it is the only digit left
    assign skip = (state_reg == ST_EMIT) && !started_reg && (top_digit == '0) && !cnt_one;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        mag_next       = mag_reg;
        radix_eff_next = radix_eff_reg;
        radix_next     = radix_we ? radix_wdata : radix_reg;
        cell_ctrl      = '0;
        ld             = 1'b0;
        ld_char        = CH_MINUS;
        ld_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next = value_u[VALUE_WIDTH-1];
                    mag_next = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
                    if (radix_reg < RADIX_MIN)
                        radix_eff_next = RADIX_MIN;
                    else if (radix_reg > RADIX_MAX)
                        radix_eff_next = RADIX_MAX;
                    else
                        radix_eff_next = radix_reg;
                    cnt_next        = CNT_W'(VALUE_WIDTH);
                    cell_ctrl.clear = 1'b1;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Advance one magnitude bit, MSB first, into the cells
                cell_ctrl.shift_in = 1'b1;
                mag_next           = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next           = cnt_reg - CNT_W'(1);
                if (cnt_one)
                begin
                    cnt_next     = CNT_W'(VALUE_WIDTH);
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (skip)
                begin
                    cell_ctrl.shift_up = 1'b1;
                    cnt_next           = cnt_reg - CNT_W'(1);
                end
                if (neg_reg)
                begin
                    // Sign goes out first; leading zeros may drop meanwhile
                    if (can_load)
                    begin
                        ld       = 1'b1;
                        ld_char  = CH_MINUS;
                        neg_next = 1'b0;
                    end
                end
                else if (!skip && can_load)
                begin
                    ld                 = 1'b1;
                    ld_char            = digit_char(top_digit);
                    ld_last            = cnt_one;
                    cell_ctrl.shift_up = 1'b1;
                    started_next       = 1'b1;
                    cnt_next           = cnt_reg - CNT_W'(1);
                    if (cnt_one)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            radix_reg   <= RADIX_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            radix_reg   <= radix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        radix_eff_reg <= radix_eff_next;
    end

    sirdx_cell_row #(
        .NUM_CELLS (VALUE_WIDTH)
    ) u_cells (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .radix     (radix_eff_reg),
        .bit_in    (mag_reg[VALUE_WIDTH-1]),
        .top_digit (top_digit)
    );

    sirdx_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ld),
        .load_char (ld_char),
        .load_last (ld_last),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    // No character is produced outside emission
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EMIT) |-> !ld)
        else $error("character loaded outside emission");

    // The final character returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ld && ld_last) |=> (state_reg == ST_IDLE))
        else $error("last character did not end the item");

    // The sign never follows a digit of the same number
    assert property (@(posedge clk) disable iff (!rst_n)
        (ld && neg_reg) |-> !started_reg)
        else $error("sign emitted after a digit");

    // Conversion always hands over to emission with a full digit count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && state_next == ST_EMIT) |=> (cnt_reg == CNT_W'(VALUE_WIDTH)))
        else $error("emission started with a wrong digit count");

endmodule

// ===== design/sirdx_cell_row.sv =====
module sirdx_cell_row #(
    parameter int NUM_CELLS = 32
) (
    input  logic                         clk,
    input  sirdx_pkg::cell_ctrl_t        ctrl,
    input  logic [sirdx_pkg::DIGIT_W-1:0] radix,
    input  logic                         bit_in,
    output logic [sirdx_pkg::DIGIT_W-1:0] top_digit
);
    import sirdx_pkg::*;

    logic [DIGIT_W-1:0] cell_reg  [NUM_CELLS];
    logic [DIGIT_W-1:0] cell_next [NUM_CELLS];

    // Each cell holds one digit below the radix; a new bit enters cell 0 and
    // the carry (2*digit + carry_in >= radix) ripples upwards like an adder carry.
    always_comb
    begin
        logic [DIGIT_W:0] r_ext;
        logic [DIGIT_W:0] dbl;
        logic [DIGIT_W:0] sum;
        logic             c;
        logic             cout;
        r_ext = {1'b0, radix};
        c     = bit_in;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            dbl  = {cell_reg[i], 1'b0};
            sum  = dbl | {{DIGIT_W{1'b0}}, c};
            cout = (dbl >= r_ext) || (c && (dbl == (r_ext - 7'd1)));
            if (ctrl.clear)
                cell_next[i] = '0;
            else if (ctrl.shift_in)
                cell_next[i] = cout ? DIGIT_W'(sum - r_ext) : sum[DIGIT_W-1:0];
            else if (ctrl.shift_up)
                cell_next[i] = (i == 0) ? '0 : cell_reg[(i == 0) ? 0 : i-1];
            else
                cell_next[i] = cell_reg[i];
            c = cout;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_CELLS; i++)
            cell_reg[i] <= cell_next[i];
    end

    assign top_digit = cell_reg[NUM_CELLS-1];

endmodule

// ===== design/sirdx_out_stage.sv =====
module sirdx_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [sirdx_pkg::CHAR_W-1:0] load_char,
    input  logic                         load_last,
    output logic                         can_load,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sirdx_pkg::CHAR_W-1:0] char_code,
    output logic                         last_char
);
    import sirdx_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    // Free when empty or when the held character transfers this cycle
    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= load_char;
            last_reg <= load_last;
        end
    end

    assign out_valid = valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule
